### hw/rtl/tps_pkg.sv
// Shared codes for the timestamp pair synchronizer: result kinds, command codes,
// configuration register indexes and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package tps_pkg;

    // Command carried in the input tuser field.
    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_SELECT  = 1'b1;

    // Result kinds.
    localparam logic [2:0] KIND_ARRIVAL = 3'd0;
    localparam logic [2:0] KIND_NONE    = 3'd1;
    localparam logic [2:0] KIND_SINGLE  = 3'd2;
    localparam logic [2:0] KIND_PAIRED  = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TWO_SENSORS  = 2'd0;
    localparam logic [1:0] CFG_QUEUE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_MAX_PAIR_GAP = 2'd2;
    localparam logic [1:0] CFG_STALE_LIMIT  = 2'd3;

    // Register reset values and the floor of the stale limit.
    localparam logic [3:0]  RST_QUEUE_LIMIT  = 4'd8;
    localparam logic [31:0] RST_MAX_PAIR_GAP = 32'd60000;
    localparam logic [31:0] RST_STALE_LIMIT  = 32'd120000;
    localparam logic [31:0] MIN_STALE        = 32'd1000;

endpackage

### hw/rtl/tps_queue_mem.sv
// One sensor's frame queue storage: a single-port-write, single-port-read RAM
// with a registered read. Uses no package.
`timescale 1ns / 1ps

module tps_queue_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 80
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/timestamp_pair_synchronizer.sv
// Timestamp pair synchronizer. Two stamp-sorted frame queues, one per sensor, live in
// two RAMs (one per sensor) kept as circular buffers with a head pointer and fill count.
// An arrival word moves each queued frame with a later stamp one slot down, by a read and
// a write per frame; a full queue first reads out the dropped oldest frame. A select tick
// in paired mode walks every pair of queued frames, one pair per cycle through the two RAM
// read ports. One word is worked on at a time; the input is ready again as soon as the
// result sits in the output register, even while that word waits to be taken.
// Configuration writes are always accepted and must be made while the block is idle.
`timescale 1ns / 1ps

module timestamp_pair_synchronizer #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TIME_BITS   = 32,
    parameter int TAG_BITS    = 16,
    localparam int IN_RAW     = 2 * TIME_BITS + TAG_BITS,
    localparam int IN_W       = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW    = 32 + 1 + 3 * TAG_BITS + 1 + 3 * TIME_BITS + 4,
    localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Input stream.
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // tdata from bit 0: frame_stamp, frame_tag, current_time, zero fill.
    input  logic [IN_W-1:0]     i_s_tdata,
    // tuser from bit 0: command, sensor_id.
    input  logic [1:0]          i_s_tuser,

    // Result stream.
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // tdata from bit 0: assigned_sequence, overflow_drop, dropped_tag, first_sensor,
    // first_tag, second_tag, pair_gap, oldest_age, superseded_count, output_stamp, zero fill.
    output logic [OUT_W-1:0]    o_m_tdata,
    // tuser: kind.
    output logic [2:0]          o_m_tuser,

    // Configuration write channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_data
);

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int LIM_W   = (CNT_W > 4) ? CNT_W + 1 : 5;
    localparam int CMP_W   = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int EW      = 2 * TIME_BITS + TAG_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ARR_DROP = 4'd1;
    localparam logic [3:0] S_ARR_DRPW = 4'd2;
    localparam logic [3:0] S_INS_RD   = 4'd3;
    localparam logic [3:0] S_INS_CMP  = 4'd4;
    localparam logic [3:0] S_SEL_HEAD = 4'd5;
    localparam logic [3:0] S_SEL_OUT  = 4'd6;
    localparam logic [3:0] S_SRCH     = 4'd7;
    localparam logic [3:0] S_SRCH_END = 4'd8;
    localparam logic [3:0] S_PAIR_CHK = 4'd9;
    localparam logic [3:0] S_PAIR_OUT = 4'd10;
    localparam logic [3:0] S_TO_RD    = 4'd11;
    localparam logic [3:0] S_TO_OUT   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // Logical queue position to RAM address.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Configuration registers.
    logic        r_two;
    logic [3:0]  r_qlim;
    logic [31:0] r_gap_lim;
    logic [31:0] r_stale;

    // Control state.
    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_head [2];
    logic [IDX_W-1:0] n_head [2];
    logic [CNT_W-1:0] r_fill [2];
    logic [CNT_W-1:0] n_fill [2];
    logic [31:0]      r_seq_cnt [2];
    logic [31:0]      n_seq_cnt [2];
    logic [CNT_W-1:0] r_p, n_p;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_pi, n_pi, r_pj, n_pj, r_ba, n_ba, r_bb, n_bb;
    logic             r_pv, n_pv, r_have, n_have;
    logic [TIME_BITS-1:0] r_best, n_best;

    // Current word.
    logic                 r_sid, n_sid;
    logic [TIME_BITS-1:0] r_stamp, n_stamp, r_now, n_now;
    logic [TAG_BITS-1:0]  r_tag, n_tag;

    // Result being built.
    logic [2:0]           r_kind, n_kind;
    logic [31:0]          r_seq, n_seq;
    logic                 r_ovf, n_ovf, r_fs, n_fs;
    logic [TAG_BITS-1:0]  r_dtag, n_dtag, r_ftag, n_ftag, r_stag, n_stag;
    logic [TIME_BITS-1:0] r_pgap, n_pgap, r_age, n_age, r_ostamp, n_ostamp;
    logic [3:0]           r_sup, n_sup;

    // Output register.
    logic             r_m_valid, n_m_valid;
    logic [OUT_W-1:0] r_m_data, n_m_data;
    logic [2:0]       r_m_user, n_m_user;

    // RAM ports.
    logic             m_we [2];
    logic [IDX_W-1:0] m_waddr [2];
    logic [EW-1:0]    m_wdata [2];
    logic [IDX_W-1:0] m_raddr [2];
    logic [EW-1:0]    m_q [2];

    for (genvar g = 0; g < 2; g++) begin : g_mem
        tps_queue_mem #(
            .DEPTH  (QUEUE_DEPTH),
            .ADDR_W (IDX_W),
            .DATA_W (EW)
        ) u_mem (
            .i_clk   (i_clk),
            .i_we    (m_we[g]),
            .i_waddr (m_waddr[g]),
            .i_wdata (m_wdata[g]),
            .i_raddr (m_raddr[g]),
            .o_rdata (m_q[g])
        );
    end

    // Fields of the entries read last cycle.
    logic [TIME_BITS-1:0] q_stamp0, q_stamp1, q_arr0, q_arr1;
    logic [TAG_BITS-1:0]  q_tag0, q_tag1;
    assign q_stamp0 = m_q[0][TIME_BITS-1:0];
    assign q_stamp1 = m_q[1][TIME_BITS-1:0];
    assign q_arr0   = m_q[0][TIME_BITS +: TIME_BITS];
    assign q_arr1   = m_q[1][TIME_BITS +: TIME_BITS];
    assign q_tag0   = m_q[0][2*TIME_BITS +: TAG_BITS];
    assign q_tag1   = m_q[1][2*TIME_BITS +: TAG_BITS];

    // Effective queue limit, clamped to 1..QUEUE_DEPTH.
    logic [CNT_W-1:0] eff_lim;
    always_comb begin
        if (r_qlim == 4'd0) begin
            eff_lim = CNT_W'(1);
        end else if (LIM_W'(r_qlim) > LIM_W'(QUEUE_DEPTH)) begin
            eff_lim = CNT_W'(QUEUE_DEPTH);
        end else begin
            eff_lim = CNT_W'(r_qlim);
        end
    end

    logic [31:0] stale_eff;
    assign stale_eff = (r_stale < tps_pkg::MIN_STALE) ? tps_pkg::MIN_STALE : r_stale;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_user;

    // Working values for the select paths.
    logic [TIME_BITS-1:0] diff, age0, age1, age_s;
    logic [5:0]           sup_sum;
    logic                 to_s;
    always_comb begin
        diff    = (q_stamp0 >= q_stamp1) ? q_stamp0 - q_stamp1 : q_stamp1 - q_stamp0;
        age0    = r_now - q_arr0;
        age1    = r_now - q_arr1;
        sup_sum = 6'(r_ba) + 6'(r_bb);
        if (r_fill[0] != '0 && r_fill[1] != '0) begin
            to_s = (q_arr0 <= q_arr1) ? 1'b0 : 1'b1;
        end else begin
            to_s = (r_fill[0] != '0) ? 1'b0 : 1'b1;
        end
        age_s = to_s ? age1 : age0;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_fill    = r_fill;
        n_seq_cnt = r_seq_cnt;
        n_p = r_p;   n_i = r_i;   n_j = r_j;   n_pi = r_pi; n_pj = r_pj;
        n_ba = r_ba; n_bb = r_bb; n_pv = r_pv; n_have = r_have; n_best = r_best;
        n_sid = r_sid; n_stamp = r_stamp; n_now = r_now; n_tag = r_tag;
        n_kind = r_kind; n_seq = r_seq; n_ovf = r_ovf; n_fs = r_fs;
        n_dtag = r_dtag; n_ftag = r_ftag; n_stag = r_stag;
        n_pgap = r_pgap; n_age = r_age; n_ostamp = r_ostamp; n_sup = r_sup;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        for (int s = 0; s < 2; s++) begin
            m_we[s]    = 1'b0;
            m_waddr[s] = '0;
            m_wdata[s] = m_q[s];
            m_raddr[s] = r_head[s];
        end

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_sid   = i_s_tuser[1];
                    n_stamp = i_s_tdata[TIME_BITS-1:0];
                    n_tag   = i_s_tdata[TIME_BITS +: TAG_BITS];
                    n_now   = i_s_tdata[TIME_BITS+TAG_BITS +: TIME_BITS];
                    n_seq = '0; n_ovf = 1'b0; n_fs = 1'b0; n_dtag = '0; n_ftag = '0;
                    n_stag = '0; n_pgap = '0; n_age = '0; n_ostamp = '0; n_sup = '0;
                    if (i_s_tuser[0] == tps_pkg::CMD_ARRIVAL) begin
                        n_kind = tps_pkg::KIND_ARRIVAL;
                        if (r_two || !i_s_tuser[1]) begin
                            n_seq_cnt[i_s_tuser[1]] = r_seq_cnt[i_s_tuser[1]] + 32'd1;
                            n_seq = r_seq_cnt[i_s_tuser[1]] + 32'd1;
                            if (r_fill[i_s_tuser[1]] >= eff_lim) begin
                                n_state = S_ARR_DROP;
                            end else begin
                                n_p     = r_fill[i_s_tuser[1]];
                                n_state = S_INS_RD;
                            end
                        end
                    end else begin
                        n_kind = tps_pkg::KIND_NONE;
                        if (!r_two) begin
                            n_state = (r_fill[0] == '0) ? S_DONE : S_SEL_HEAD;
                        end else if (r_fill[0] != '0 && r_fill[1] != '0) begin
                            n_i = '0; n_j = '0; n_pv = 1'b0; n_have = 1'b0;
                            n_state = S_SRCH;
                        end else if (r_fill[0] == '0 && r_fill[1] == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_TO_RD;
                        end
                    end
                end
            end

            // The head address is already on the read port by default.
            S_ARR_DROP: n_state = S_ARR_DRPW;

            S_ARR_DRPW: begin
                n_ovf  = 1'b1;
                n_dtag = r_sid ? q_tag1 : q_tag0;
                n_head[r_sid] = phys(r_head[r_sid], CNT_W'(1));
                n_fill[r_sid] = r_fill[r_sid] - CNT_W'(1);
                n_p     = r_fill[r_sid] - CNT_W'(1);
                n_state = S_INS_RD;
            end

            S_INS_RD: begin
                if (r_p == '0) begin
                    m_we[r_sid]    = 1'b1;
                    m_waddr[r_sid] = r_head[r_sid];
                    m_wdata[r_sid] = {r_tag, r_now, r_stamp};
                    n_fill[r_sid]  = r_fill[r_sid] + CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    m_raddr[r_sid] = phys(r_head[r_sid], r_p - CNT_W'(1));
                    n_state = S_INS_CMP;
                end
            end

            // Entries with a later stamp move one slot toward the tail.
            S_INS_CMP: begin
                m_we[r_sid]    = 1'b1;
                m_waddr[r_sid] = phys(r_head[r_sid], r_p);
                if ((r_sid ? q_stamp1 : q_stamp0) > r_stamp) begin
                    m_wdata[r_sid] = m_q[r_sid];
                    n_p     = r_p - CNT_W'(1);
                    n_state = S_INS_RD;
                end else begin
                    m_wdata[r_sid] = {r_tag, r_now, r_stamp};
                    n_fill[r_sid]  = r_fill[r_sid] + CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_SEL_HEAD: n_state = S_SEL_OUT;

            S_SEL_OUT: begin
                n_kind   = tps_pkg::KIND_SINGLE;
                n_ftag   = q_tag0;
                n_age    = age0;
                n_ostamp = q_stamp0;
                n_head[0] = phys(r_head[0], CNT_W'(1));
                n_fill[0] = r_fill[0] - CNT_W'(1);
                n_state  = S_DONE;
            end

            S_SRCH, S_SRCH_END: begin
                if (r_pv && (!r_have || diff < r_best)) begin
                    n_have = 1'b1;
                    n_best = diff;
                    n_ba   = r_pi;
                    n_bb   = r_pj;
                end
                if (r_state == S_SRCH) begin
                    m_raddr[0] = phys(r_head[0], CNT_W'(r_i));
                    m_raddr[1] = phys(r_head[1], CNT_W'(r_j));
                    n_pv = 1'b1;
                    n_pi = r_i;
                    n_pj = r_j;
                    if (CNT_W'(r_j) == r_fill[1] - CNT_W'(1)) begin
                        n_j = '0;
                        if (CNT_W'(r_i) == r_fill[0] - CNT_W'(1)) begin
                            n_state = S_SRCH_END;
                        end else begin
                            n_i = r_i + IDX_W'(1);
                        end
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_PAIR_CHK;
                end
            end

            // Either fetch the chosen pair or fall back to the heads.
            S_PAIR_CHK: begin
                if (CMP_W'(r_best) <= CMP_W'(r_gap_lim)) begin
                    m_raddr[0] = phys(r_head[0], CNT_W'(r_ba));
                    m_raddr[1] = phys(r_head[1], CNT_W'(r_bb));
                    n_state = S_PAIR_OUT;
                end else begin
                    n_state = S_TO_OUT;
                end
            end

            S_PAIR_OUT: begin
                n_kind   = tps_pkg::KIND_PAIRED;
                n_ftag   = q_tag0;
                n_stag   = q_tag1;
                n_pgap   = r_best;
                n_age    = (age0 > age1) ? age0 : age1;
                n_ostamp = (q_stamp0 > q_stamp1) ? q_stamp0 : q_stamp1;
                n_sup    = (sup_sum > 6'd15) ? 4'd15 : sup_sum[3:0];
                n_head[0] = phys(r_head[0], CNT_W'(r_ba) + CNT_W'(1));
                n_head[1] = phys(r_head[1], CNT_W'(r_bb) + CNT_W'(1));
                n_fill[0] = r_fill[0] - CNT_W'(r_ba) - CNT_W'(1);
                n_fill[1] = r_fill[1] - CNT_W'(r_bb) - CNT_W'(1);
                n_state  = S_DONE;
            end

            S_TO_RD: n_state = S_TO_OUT;

            S_TO_OUT: begin
                if (CMP_W'(age_s) >= CMP_W'(stale_eff)) begin
                    n_kind   = tps_pkg::KIND_TIMEOUT;
                    n_fs     = to_s;
                    n_ftag   = to_s ? q_tag1 : q_tag0;
                    n_age    = age_s;
                    n_ostamp = to_s ? q_stamp1 : q_stamp0;
                    n_head[to_s] = phys(r_head[to_s], CNT_W'(1));
                    n_fill[to_s] = r_fill[to_s] - CNT_W'(1);
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_user  = r_kind;
                    n_m_data  = OUT_W'({r_ostamp, r_sup, r_age, r_pgap, r_stag, r_ftag,
                                        r_fs, r_dtag, r_ovf, r_seq});
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '{default: '0};
            r_fill    <= '{default: '0};
            r_seq_cnt <= '{default: '0};
            r_pv      <= 1'b0;
            r_have    <= 1'b0;
            r_m_valid <= 1'b0;
            r_two     <= 1'b1;
            r_qlim    <= tps_pkg::RST_QUEUE_LIMIT;
            r_gap_lim <= tps_pkg::RST_MAX_PAIR_GAP;
            r_stale   <= tps_pkg::RST_STALE_LIMIT;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_seq_cnt <= n_seq_cnt;
            r_pv      <= n_pv;
            r_have    <= n_have;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    tps_pkg::CFG_TWO_SENSORS:  r_two     <= i_cfg_data[0];
                    tps_pkg::CFG_QUEUE_LIMIT:  r_qlim    <= i_cfg_data[3:0];
                    tps_pkg::CFG_MAX_PAIR_GAP: r_gap_lim <= i_cfg_data;
                    tps_pkg::CFG_STALE_LIMIT:  r_stale   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;   r_i <= n_i;   r_j <= n_j;   r_pi <= n_pi; r_pj <= n_pj;
        r_ba <= n_ba; r_bb <= n_bb; r_best <= n_best;
        r_sid <= n_sid; r_stamp <= n_stamp; r_now <= n_now; r_tag <= n_tag;
        r_kind <= n_kind; r_seq <= n_seq; r_ovf <= n_ovf; r_fs <= n_fs;
        r_dtag <= n_dtag; r_ftag <= n_ftag; r_stag <= n_stag;
        r_pgap <= n_pgap; r_age <= n_age; r_ostamp <= n_ostamp; r_sup <= n_sup;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

endmodule

### tb/timestamp_pair_synchronizer_test.sv
// Self-checking testbench for the timestamp pair synchronizer: streams arrival and
// select words, predicts every result word and compares it field by field.
// Depends on tps_pkg and the timestamp_pair_synchronizer RTL.
`timescale 1ns / 1ps

module timestamp_pair_synchronizer_test;

    localparam int DEPTH = 8;
    localparam int IN_W  = 80;   // frame_stamp, frame_tag, current_time
    localparam int OUT_W = 184;  // 182 bits of result fields plus zero fill

    // One result word, split into its fields.
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic        ovf;
        logic [15:0] dtag;
        logic        fsen;
        logic [15:0] ftag;
        logic [15:0] stag;
        logic [31:0] gap;
        logic [31:0] age;
        logic [3:0]  sup;
        logic [31:0] ostamp;
    } sync_result_t;

    // Scoreboard: keeps its own copy of both frame queues and the registers, works out
    // the result of every accepted input word and checks result words against it.
    class sync_predictor;
        logic [31:0]  stamp_q [2][DEPTH];
        logic [31:0]  arrive_q[2][DEPTH];
        logic [15:0]  tag_q   [2][DEPTH];
        int           fill[2];
        logic [31:0]  seq_cnt[2];
        logic         two_sensors;
        logic [3:0]   queue_limit;
        logic [31:0]  max_gap;
        logic [31:0]  stale_limit;
        sync_result_t expected_results[$];
        int           errors;

        function new();
            fill[0] = 0; fill[1] = 0;
            seq_cnt[0] = 0; seq_cnt[1] = 0;
            two_sensors = 1'b1;
            queue_limit = tps_pkg::RST_QUEUE_LIMIT;
            max_gap     = tps_pkg::RST_MAX_PAIR_GAP;
            stale_limit = tps_pkg::RST_STALE_LIMIT;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] addr, logic [31:0] data);
            case (addr)
                tps_pkg::CFG_TWO_SENSORS:  two_sensors = data[0];
                tps_pkg::CFG_QUEUE_LIMIT:  queue_limit = data[3:0];
                tps_pkg::CFG_MAX_PAIR_GAP: max_gap     = data;
                tps_pkg::CFG_STALE_LIMIT:  stale_limit = data;
                default: ;
            endcase
        endfunction

        // Appends one expected result word at the tail.
        function void add_expected(sync_result_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        // Takes the oldest expected result word off the head.
        function sync_result_t take_expected();
            sync_result_t e;
            e = expected_results[0];
            expected_results.delete(0);
            return e;
        endfunction

        // Remove the k oldest frames of queue s.
        function void drop_front(int s, int k);
            if (k > fill[s]) k = fill[s];
            for (int i = 0; i + k < fill[s]; i++) begin
                stamp_q[s][i]  = stamp_q[s][i + k];
                arrive_q[s][i] = arrive_q[s][i + k];
                tag_q[s][i]    = tag_q[s][i + k];
            end
            fill[s] -= k;
        endfunction

        function void note_word(logic cmd, logic sid, logic [31:0] stamp,
                                logic [15:0] tag, logic [31:0] now);
            sync_result_t r;
            int lim, pos, s, ba, bb;
            logic [31:0] best, d, aa, ab, stale_floor;
            logic have;
            r = '0;
            if (cmd == tps_pkg::CMD_ARRIVAL) begin
                // An arrival for the second sensor in single mode is dropped silently.
                if (!two_sensors && sid) return;
                seq_cnt[sid] = seq_cnt[sid] + 1;
                r.kind = tps_pkg::KIND_ARRIVAL;
                r.seq  = seq_cnt[sid];
                lim = (queue_limit < 1) ? 1 : (queue_limit > DEPTH) ? DEPTH : queue_limit;
                if (fill[sid] >= lim) begin
                    r.ovf  = 1'b1;
                    r.dtag = tag_q[sid][0];
                    drop_front(sid, 1);
                end
                // Equal stamps go behind the frames already queued.
                pos = 0;
                while (pos < fill[sid] && stamp_q[sid][pos] <= stamp) pos++;
                for (int i = fill[sid]; i > pos; i--) begin
                    stamp_q[sid][i]  = stamp_q[sid][i - 1];
                    arrive_q[sid][i] = arrive_q[sid][i - 1];
                    tag_q[sid][i]    = tag_q[sid][i - 1];
                end
                stamp_q[sid][pos]  = stamp;
                arrive_q[sid][pos] = now;
                tag_q[sid][pos]    = tag;
                fill[sid]++;
                add_expected(r);
                return;
            end
            r.kind = tps_pkg::KIND_NONE;
            if (!two_sensors) begin
                if (fill[0] > 0) begin
                    r.kind   = tps_pkg::KIND_SINGLE;
                    r.ftag   = tag_q[0][0];
                    r.age    = now - arrive_q[0][0];
                    r.ostamp = stamp_q[0][0];
                    drop_front(0, 1);
                end
                add_expected(r);
                return;
            end
            if (fill[0] > 0 && fill[1] > 0) begin
                have = 1'b0; best = 0; ba = 0; bb = 0;
                // Row-major search; a strictly smaller gap is needed to replace the best.
                for (int i = 0; i < fill[0]; i++)
                    for (int j = 0; j < fill[1]; j++) begin
                        d = (stamp_q[0][i] >= stamp_q[1][j]) ? stamp_q[0][i] - stamp_q[1][j]
                                                             : stamp_q[1][j] - stamp_q[0][i];
                        if (!have || d < best) begin
                            have = 1'b1; best = d; ba = i; bb = j;
                        end
                    end
                if (best <= max_gap) begin
                    aa = now - arrive_q[0][ba];
                    ab = now - arrive_q[1][bb];
                    r.kind   = tps_pkg::KIND_PAIRED;
                    r.ftag   = tag_q[0][ba];
                    r.stag   = tag_q[1][bb];
                    r.gap    = best;
                    r.age    = (aa > ab) ? aa : ab;
                    r.sup    = (ba + bb > 15) ? 4'd15 : 4'(ba + bb);
                    r.ostamp = (stamp_q[0][ba] > stamp_q[1][bb]) ? stamp_q[0][ba]
                                                                 : stamp_q[1][bb];
                    drop_front(0, ba + 1);
                    drop_front(1, bb + 1);
                    add_expected(r);
                    return;
                end
            end
            // Stale release of the queue head that arrived first.
            stale_floor = (stale_limit < tps_pkg::MIN_STALE) ? tps_pkg::MIN_STALE
                                                             : stale_limit;
            s = -1;
            if (fill[0] > 0 && fill[1] > 0) s = (arrive_q[0][0] <= arrive_q[1][0]) ? 0 : 1;
            else if (fill[0] > 0) s = 0;
            else if (fill[1] > 0) s = 1;
            if (s >= 0 && (now - arrive_q[s][0]) >= stale_floor) begin
                r.kind   = tps_pkg::KIND_TIMEOUT;
                r.fsen   = s[0];
                r.ftag   = tag_q[s][0];
                r.age    = now - arrive_q[s][0];
                r.ostamp = stamp_q[s][0];
                drop_front(s, 1);
            end
            add_expected(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
                         exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(sync_result_t act);
            sync_result_t e;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual kind %0d",
                         $time, act.kind);
                errors++;
                return;
            end
            e = take_expected();
            check_field("kind", e.kind, act.kind);
            check_field("assigned_sequence", e.seq, act.seq);
            check_field("overflow_drop", e.ovf, act.ovf);
            check_field("dropped_tag", e.dtag, act.dtag);
            check_field("first_sensor", e.fsen, act.fsen);
            check_field("first_tag", e.ftag, act.ftag);
            check_field("second_tag", e.stag, act.stag);
            check_field("pair_gap", e.gap, act.gap);
            check_field("oldest_age", e.age, act.age);
            check_field("superseded_count", e.sup, act.sup);
            check_field("output_stamp", e.ostamp, act.ostamp);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata;
    logic [1:0]        i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;
    logic [2:0]        o_m_tuser;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_addr;
    logic [31:0]       i_cfg_data;

    timestamp_pair_synchronizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    sync_predictor sync_model = new();

    // Flags shared by the processes: no_idle removes all random gaps on both sides,
    // hold_request makes the receiver stop taking words for a long stretch.
    logic        no_idle;
    logic        hold_request;
    logic [31:0] sim_now;
    int          idle_cycles;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_m_tready   = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_data   = '0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Draws a random idle gap, or none when idling is switched off.
    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // Sends one input word and tells the scoreboard once it has been accepted.
    task automatic send_word(logic cmd, logic sid, logic [31:0] stamp, logic [15:0] tag,
                             logic [31:0] now);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {now, tag, stamp};
        i_s_tuser  <= {sid, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        sync_model.note_word(cmd, sid, stamp, tag, now);
    endtask

    // Waits until every expected result has come back and the block has settled, so a
    // register write cannot land while an ignored word is still being worked on.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sync_model.expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Holds the write channel valid; the caller drops it after the last write.
    task automatic write_reg(logic [1:0] addr, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sync_model.write_reg(addr, data);
    endtask

    // One random word. Most words follow a plausible timeline: the local clock moves
    // forward and stamps trail it slightly, with repeated stamps for tie cases. A few
    // words are pure noise, and now and then the clock jumps far ahead so that lone
    // heads go stale.
    task automatic send_random_word();
        logic        cmd;
        logic [31:0] stamp;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                      16'($urandom), $urandom);
            return;
        end
        if (r < 11) sim_now += $urandom_range(100000, 400000);
        else        sim_now += $urandom_range(0, 40000);
        cmd = ($urandom_range(0, 99) < 55) ? tps_pkg::CMD_ARRIVAL : tps_pkg::CMD_SELECT;
        stamp = sim_now - $urandom_range(0, 30000);
        if ($urandom_range(0, 9) == 0) stamp = sim_now;
        send_word(cmd, 1'($urandom_range(0, 1)), stamp, 16'($urandom), sim_now);
    endtask

    // Receiver: random stalls before each word, and on request one long hold-off while
    // the sender keeps offering words, so the block fills up and stalls its input.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                i_m_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_request = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Result monitor: unpacks each accepted result word and hands it to the scoreboard.
    always @(posedge i_clk) begin
        sync_result_t act;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            act.kind   = o_m_tuser;
            act.seq    = o_m_tdata[31:0];
            act.ovf    = o_m_tdata[32];
            act.dtag   = o_m_tdata[48:33];
            act.fsen   = o_m_tdata[49];
            act.ftag   = o_m_tdata[65:50];
            act.stag   = o_m_tdata[81:66];
            act.gap    = o_m_tdata[113:82];
            act.age    = o_m_tdata[145:114];
            act.sup    = o_m_tdata[149:146];
            act.ostamp = o_m_tdata[181:150];
            sync_model.check_word(act);
        end
    end

    // Watchdog: the run is hung if no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000) begin
            $display("timestamp_pair_synchronizer_test: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] limits[5];
        logic [31:0] gaps[5];
        logic [31:0] stales[5];
        @(posedge i_rst_n);
        @(posedge i_clk);

        // Directed part under the reset settings. Select on empty queues gives nothing.
        send_word(tps_pkg::CMD_SELECT, 1'b0, 32'h0, 16'h0, 32'd5);
        // Extreme stamps and tags, equal stamps inserted behind each other.
        send_word(tps_pkg::CMD_ARRIVAL, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'd10);
        send_word(tps_pkg::CMD_ARRIVAL, 1'b0, 32'h0, 16'h0, 32'd20);
        send_word(tps_pkg::CMD_ARRIVAL, 1'b0, 32'd1000, 16'h1234, 32'd30);
        send_word(tps_pkg::CMD_ARRIVAL, 1'b0, 32'd1000, 16'h5678, 32'd40);
        send_word(tps_pkg::CMD_ARRIVAL, 1'b1, 32'd1500, 16'hABCD, 32'd50);
        send_word(tps_pkg::CMD_ARRIVAL, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // Pair with superseded frames at an exact stamp, then a select on the emptied queues.
        send_word(tps_pkg::CMD_SELECT, 1'b0, 32'h0, 16'h0, 32'd2000);
        send_word(tps_pkg::CMD_SELECT, 1'b1, 32'h0, 16'h0, 32'd3000);
        // Overflow: keep filling sensor 0 past the queue limit.
        for (int i = 0; i < 10; i++)
            send_word(tps_pkg::CMD_ARRIVAL, 1'b0, 32'd5000 + 32'(i) * 7, 16'(i), 32'd4000);
        // Gap too wide now, and far enough later for a stale release; ages wrap too.
        send_word(tps_pkg::CMD_ARRIVAL, 1'b1, 32'd900000, 16'h4444, 32'd4100);
        send_word(tps_pkg::CMD_SELECT, 1'b0, 32'h0, 16'h0, 32'd5000);
        send_word(tps_pkg::CMD_SELECT, 1'b0, 32'h0, 16'h0, 32'd200000);
        send_word(tps_pkg::CMD_SELECT, 1'b0, 32'h0, 16'h0, 32'd3);
        wait_drained();

        limits = '{32'd0, 32'd1, 32'd8, 32'd15, 32'd3};
        gaps   = '{32'd0, 32'hFFFF_FFFF, 32'd60000, 32'd5000, 32'd20000};
        stales = '{32'd0, 32'd999, 32'd1000, 32'hFFFF_FFFF, 32'd50000};
        for (int phase = 0; phase < 10; phase++) begin
            write_reg(tps_pkg::CFG_TWO_SENSORS, (phase % 4 == 3) ? 32'd0 : 32'd1);
            write_reg(tps_pkg::CFG_QUEUE_LIMIT,
                      (phase < 5) ? limits[phase] : $urandom_range(0, 15));
            write_reg(tps_pkg::CFG_MAX_PAIR_GAP,
                      (phase < 5) ? gaps[phase] : $urandom_range(0, 80000));
            write_reg(tps_pkg::CFG_STALE_LIMIT,
                      (phase < 5) ? stales[phase] : $urandom_range(0, 300000));
            i_cfg_valid <= 1'b0;
            no_idle = (phase == 1 || phase == 6);
            if (phase == 2) hold_request = 1'b1;
            sim_now = $urandom;
            for (int n = 0; n < 200; n++) send_random_word();
            wait_drained();
        end

        if (sync_model.errors == 0 && sync_model.expected_results.size() == 0) begin
            $display("timestamp_pair_synchronizer_test: PASS");
        end else begin
            $display("timestamp_pair_synchronizer_test: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tps_pkg.sv
hw/rtl/tps_queue_mem.sv
hw/rtl/timestamp_pair_synchronizer.sv
tb/timestamp_pair_synchronizer_test.sv
